// File: src/frst_pkg.sv
// shared types and constants for the fenwick range-sum tree
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package frst_pkg;

   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;

   // request kinds carried on req_type
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_QUERY,
      ST_DONE
   } state_type;

endpackage

// File: src/fenwick_range_sum_tree.sv
// an add holds req_stall high while it walks up the tree; a query gives rsp_valid once its
// prefix walks are done and the response register is free
// one item at a time: the next request is taken only back in idle, and a finished query waits
// in ST_DONE while a stalled response is held; one tree node read per cycle
// reset: synchronous; a clearing pass zeroes the tree memory,
// req_stall stays high until it finishes; depends on frst_pkg
`timescale 1ns / 1ps

module fenwick_range_sum_tree #(
   parameter int ENTRIES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [frst_pkg::IDX_W-1:0]       req_index,
   input  logic [frst_pkg::IDX_W-1:0]       req_right_index,
   input  logic signed [frst_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [frst_pkg::DATA_W-1:0] rsp_range_total
);

   localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PW_T = $clog2(2 * ENTRIES + 1);
   // position must hold index+1 and twice the number of entries
   localparam int PW   = (PW_T > frst_pkg::IDX_W + 1) ? PW_T : frst_pkg::IDX_W + 1;
   localparam int DW   = frst_pkg::DATA_W;

   logic [DW-1:0] tree_mem [ENTRIES];

   frst_pkg::state_type state_ff, state_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic                       phase_ff, phase_in;
   logic                       pend_ff, pend_in;
   logic                       pend_sub_ff, pend_sub_in;
   logic [AW-1:0]              pend_addr_ff, pend_addr_in;
   logic [DW-1:0]              acc_ff, acc_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [frst_pkg::IDX_W-1:0] left_ff, left_in;
   logic [DW-1:0]              value_ff, value_in;
   logic [DW-1:0]              rdata_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]              rsp_total_ff;

   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [DW-1:0]              wr_data;
   logic                       rsp_load;
   logic [PW-1:0]              pos_m1;
   logic [PW-1:0]              pos_low;

   function automatic logic [PW-1:0] ext_idx(input logic [frst_pkg::IDX_W-1:0] x);
      ext_idx = {{(PW - frst_pkg::IDX_W){1'b0}}, x};
   endfunction

   // prefix bounds past the tree clamp to the whole tree
   function automatic logic [PW-1:0] sat_pos(input logic [PW-1:0] p);
      sat_pos = (p > PW'(ENTRIES)) ? PW'(ENTRIES) : p;
   endfunction

   assign pos_m1  = pos_ff - PW'(1);
   assign pos_low = pos_ff & (~pos_ff + PW'(1));

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      pend_in      = 1'b0;
      pend_sub_in  = phase_ff;
      pend_addr_in = pend_addr_ff;
      acc_in       = acc_ff;
      clr_in       = clr_ff;
      left_in      = left_ff;
      value_in     = value_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_m1[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rdata_ff + value_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         frst_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = frst_pkg::ST_IDLE;
            end
         end
         frst_pkg::ST_IDLE: begin
            if (req_valid) begin
               value_in = $unsigned(req_value);
               left_in  = req_index;
               acc_in   = '0;
               phase_in = 1'b0;
               if (req_type == frst_pkg::REQ_ADD) begin
                  pos_in   = ext_idx(req_index) + PW'(1);
                  state_in = frst_pkg::ST_ADD;
               end else begin
                  pos_in   = sat_pos(ext_idx(req_right_index) + PW'(1));
                  state_in = frst_pkg::ST_QUERY;
               end
            end
         end
         frst_pkg::ST_ADD: begin
            // positions climb strictly, so the write back never hits the word being read
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (pos_ff <= PW'(ENTRIES)) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = pos_m1[AW-1:0];
               pos_in       = pos_ff + pos_low;
            end else if (!pend_ff) begin
               state_in = frst_pkg::ST_IDLE;
            end
         end
         frst_pkg::ST_QUERY: begin
            if (pend_ff) begin
               acc_in = pend_sub_ff ? acc_ff - rdata_ff : acc_ff + rdata_ff;
            end
            if (pos_ff != '0) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pos_in  = pos_ff - pos_low;
            end else if (!phase_ff && (left_ff != '0)) begin
               // second walk: prefix just below the left bound, subtracted
               phase_in = 1'b1;
               pos_in   = sat_pos(ext_idx(left_ff));
            end else if (!pend_ff) begin
               state_in = frst_pkg::ST_DONE;
            end
         end
         frst_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = frst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      phase_ff     <= phase_in;
      pend_sub_ff  <= pend_sub_in;
      pend_addr_ff <= pend_addr_in;
      acc_ff       <= acc_in;
      left_ff      <= left_in;
      value_ff     <= value_in;
      if (rsp_load) begin
         rsp_total_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= tree_mem[rd_addr];
      end
   end

   assign req_stall       = (state_ff != frst_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = $signed(rsp_total_ff);

endmodule

// File: src/frst_checker.sv
// port-level checks for the fenwick range-sum tree, bound to the top level
// depends on frst_pkg for field widths
`timescale 1ns / 1ps

module frst_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [frst_pkg::DATA_W-1:0] rsp_range_total
);

   // the clearing pass holds off requests right after reset
   a_reset_stalls: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one item at a time: a taken beat makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // a new response only comes out of a busy block
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a query in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_range_total)))
      else $error("stalled response changed");

endmodule

bind fenwick_range_sum_tree frst_checker u_frst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_range_total (rsp_range_total)
);
